>>> hdl/trf_pkg.sv
// Package for the tandem repeat finder: sizes, constants and shared types.
// No dependencies; every other file of the block depends on it.
`default_nettype none
package trf_pkg;
    localparam int MAX_PERIOD = 10;
    localparam int POS_BITS = 24;
    localparam int HIST_DEPTH = 2 * MAX_PERIOD;
    localparam int LEN_BITS = 4;
    localparam int SYM_BITS = 8;
    localparam int FLD_BITS = 24;
    localparam int MAX_RESULTS = 53;
    localparam int RCNT_BITS = $clog2(MAX_RESULTS + 1);
    localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};
    localparam logic [FLD_BITS-1:0] FIELD_MAX = {FLD_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] MIN_RESET = 4'd3;
    localparam logic [LEN_BITS-1:0] MAX_RESET = 4'd10;
    localparam logic [0:0] REG_MIN = 1'b0;
    localparam logic [0:0] REG_MAX = 1'b1;
    localparam logic ACT_SYMBOL = 1'b0;
    localparam logic ACT_END = 1'b1;

    typedef struct packed {
        logic                found;
        logic [FLD_BITS-1:0] start_pos;
        logic [LEN_BITS-1:0] period;
        logic [FLD_BITS-1:0] repeat_count;
        logic                last;
    } result_t;

    typedef struct packed {
        logic                shift;
        logic                clear;
        logic                enable;
        logic [POS_BITS-1:0] pos;
        logic [SYM_BITS-1:0] sym;
        logic [LEN_BITS-1:0] lo;
        logic [LEN_BITS-1:0] hi;
    } cell_ctl_t;

    function automatic logic [FLD_BITS-1:0] sat_field(input logic [2*POS_BITS-1:0] v);
        sat_field = (v > {{POS_BITS{1'b0}}, FIELD_MAX}) ? FIELD_MAX : v[FLD_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/trf_if.sv
// Valid/ready channel interfaces for the tandem repeat finder.
// Depends on trf_pkg.
`default_nettype none
interface trf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [trf_pkg::SYM_BITS-1:0] symbol;
    modport source (output valid, action, symbol, input ready);
    modport sink (input valid, action, symbol, output ready);
endinterface

interface trf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [trf_pkg::FLD_BITS-1:0] start_pos;
    logic [trf_pkg::LEN_BITS-1:0] period;
    logic [trf_pkg::FLD_BITS-1:0] repeat_count;
    logic                         last;
    modport source (output valid, found, start_pos, period, repeat_count, last, input ready);
    modport sink (input valid, found, start_pos, period, repeat_count, last, output ready);
endinterface

interface trf_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [0:0]                   index;
    logic [trf_pkg::LEN_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/trf_cell.sv
// One period cell: compares the stream against itself delayed by its period and
// tracks run counts per position slot. Depends on trf_pkg.
`default_nettype none
module trf_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [trf_pkg::LEN_BITS-1:0] len,
    input  trf_pkg::cell_ctl_t                ctl,
    input  wire logic [trf_pkg::SYM_BITS-1:0] hist_in,
    output logic [trf_pkg::SYM_BITS-1:0]      hist_out,
    output logic                              rep_valid,
    output trf_pkg::result_t                  rep,
    input  wire logic [trf_pkg::LEN_BITS-1:0] flush_idx,
    output logic [trf_pkg::POS_BITS-1:0]      flush_cnt
);
    import trf_pkg::*;

    logic [POS_BITS-1:0] cnt_reg [MAX_PERIOD];
    logic [POS_BITS-1:0] cnt_next [MAX_PERIOD];
    logic [LEN_BITS-1:0] mism_reg;
    logic [LEN_BITS-1:0] mism_next;
    logic                same;
    logic                in_rng;
    logic [LEN_BITS-1:0] oidx;
    logic [POS_BITS-1:0] old;
    logic [POS_BITS-1:0] nv;
    logic                match;
    logic [2*POS_BITS-1:0] span;
    logic [POS_BITS:0]   q1;

    // The counter holds the number of consecutive equal pairs, saturating at len.
    assign same = (ctl.sym == hist_in);
    assign hist_out = ctl.sym;
    assign in_rng = (len >= ctl.lo) && (len <= ctl.hi);
    assign oidx = LEN_BITS'(MAX_PERIOD) - len;
    assign old = (ctl.pos >= {{(POS_BITS-LEN_BITS){1'b0}}, len}) ? cnt_reg[oidx] : '0;
    assign match = (ctl.pos + 1'b1 >= {{(POS_BITS-LEN_BITS-1){1'b0}}, len, 1'b0})
                   && same && (mism_reg + 1'b1 >= len);
    assign span = old * {{(POS_BITS-LEN_BITS){1'b0}}, len};
    assign q1 = {1'b0, ctl.pos} - {{(POS_BITS-LEN_BITS+1){1'b0}}, len} + 1'b1;

    always_comb
    begin
        mism_next = mism_reg;
        if (same)
        begin
            if (mism_reg < len)
            begin
                mism_next = mism_reg + 1'b1;
            end
        end
        else
        begin
            mism_next = '0;
        end
        if (match)
        begin
            nv = (old == '0) ? POS_BITS'(2) : ((old == POS_LIMIT) ? POS_LIMIT : old + 1'b1);
        end
        else
        begin
            nv = POS_BITS'(1);
        end
        for (int i = 0; i < MAX_PERIOD; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (ctl.shift)
        begin
            // Index MAX_PERIOD-k holds position p-k; entries move down by one per symbol.
            for (int i = 0; i < MAX_PERIOD - 1; i++)
            begin
                cnt_next[i] = cnt_reg[i+1];
            end
            cnt_next[MAX_PERIOD-1] = in_rng ? nv : '0;
        end
        rep_valid = ctl.enable && in_rng && !match && (old > POS_BITS'(1));
        rep.found = 1'b1;
        rep.start_pos = (span > {{POS_BITS{1'b0}}, q1[POS_BITS-1:0]}) || q1[POS_BITS] ? '0
                        : sat_field({{POS_BITS{1'b0}}, q1[POS_BITS-1:0]} - span);
        rep.period = len;
        rep.repeat_count = sat_field({{POS_BITS{1'b0}}, old});
        rep.last = 1'b0;
    end

    assign flush_cnt = cnt_reg[flush_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mism_reg <= '0;
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            mism_reg <= '0;
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctl.shift)
        begin
            mism_reg <= mism_next;
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/trf_hist.sv
// Symbol delay line feeding each period cell its delayed symbol.
// Depends on trf_pkg.
`default_nettype none
module trf_hist (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         shift,
    input  wire logic                         clear,
    input  wire logic [trf_pkg::SYM_BITS-1:0] sym,
    output logic [trf_pkg::SYM_BITS-1:0]      tap [trf_pkg::MAX_PERIOD]
);
    import trf_pkg::*;

    logic [SYM_BITS-1:0] line_reg [MAX_PERIOD];

    always_comb
    begin
        for (int i = 0; i < MAX_PERIOD; i++)
        begin
            tap[i] = line_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            line_reg[0] <= sym;
            for (int i = 1; i < MAX_PERIOD; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/tandem_repeat_finder.sv
// Top level of the tandem repeat finder: a row of period cells and a sequencer.
// Depends on trf_pkg, trf_if, trf_hist and trf_cell.
//
// Usage: symbol items enter on in_ch (action 0) and an end item (action 1)
// closes a sequence. Results leave on out_ch; registers min_period (index 0)
// and max_period (index 1) are to be written on cfg_ch only while the block
// is idle; the block itself does not enforce this. A symbol item is latched
// in the idle state, then every cell compares it against the symbol one period
// back and updates its counts. Reports of that symbol are then handed out one
// per cycle by scanning the cells in ascending period; a symbol with no report
// frees the block at once. An end item scans ten position slots times ten
// periods, one cell count per cycle, then emits the closing record with last
// set. The output register holds a result until the receiver takes it; while it
// waits the scan halts, but a new item is still taken once the block is idle.
// Reset clears history, counts, position and sets the registers to 3 and 10.
`default_nettype none
module tandem_repeat_finder (
    input wire logic clk,
    input wire logic rst_n,
    trf_in_if.sink   in_ch,
    trf_out_if.source out_ch,
    trf_cfg_if.sink  cfg_ch
);
    import trf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_REP   = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_CLOSE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_BITS-1:0] min_reg, max_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [SYM_BITS-1:0] sym_reg;
    logic                act_reg;
    logic [MAX_PERIOD-1:0] rep_mask_reg;
    result_t             rep_buf_reg [MAX_PERIOD];
    logic [LEN_BITS-1:0] q_reg;
    logic [LEN_BITS-1:0] l_reg;
    logic [RCNT_BITS-1:0] n_reg;
    logic                ovalid_reg;
    result_t             obuf_reg;
    logic [LEN_BITS-1:0] lo, hi;
    cell_ctl_t           ctl;
    logic [SYM_BITS-1:0] tap [MAX_PERIOD];
    logic [SYM_BITS-1:0] hout [MAX_PERIOD];
    logic [MAX_PERIOD-1:0] rv;
    result_t             rp [MAX_PERIOD];
    logic [POS_BITS-1:0] fc [MAX_PERIOD];
    logic [LEN_BITS-1:0] fidx;
    logic                obuf_free;
    logic                ovalid_load;
    logic [LEN_BITS-1:0] rsel;
    logic                rany;
    logic [MAX_PERIOD-1:0] rest;
    result_t             rsel_res;
    logic [POS_BITS-1:0] qabs;
    logic [POS_BITS-1:0] qbase;
    logic [POS_BITS-1:0] c;
    logic                fvalid;
    logic [2*POS_BITS-1:0] fspan;
    logic [POS_BITS:0]   fq1;

    assign lo = (min_reg == '0) ? LEN_BITS'(1) : min_reg;
    assign hi = (max_reg > LEN_BITS'(MAX_PERIOD)) ? LEN_BITS'(MAX_PERIOD) : max_reg;
    assign obuf_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign ctl.shift = (state_reg == ST_EVAL) && (act_reg == ACT_SYMBOL) && (pos_reg < POS_LIMIT);
    assign ctl.enable = ctl.shift;
    assign ctl.clear = (state_reg == ST_CLOSE) && obuf_free;
    assign ctl.pos = pos_reg;
    assign ctl.sym = sym_reg;
    assign ctl.lo = lo;
    assign ctl.hi = hi;

    trf_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctl.shift),
        .clear (ctl.clear),
        .sym   (sym_reg),
        .tap   (tap)
    );

    // Flush slot q_reg is position qbase+q_reg; with P positions done,
    // position P-k sits at index MAX_PERIOD-k in every cell.
    assign qbase = (pos_reg > POS_BITS'(MAX_PERIOD)) ? pos_reg - POS_BITS'(MAX_PERIOD) : '0;
    assign qabs = qbase + {{(POS_BITS-LEN_BITS){1'b0}}, q_reg};
    assign fidx = LEN_BITS'(POS_BITS'(MAX_PERIOD) - (pos_reg - qabs));

    for (genvar g = 0; g < MAX_PERIOD; g++)
    begin : g_cell
        trf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .len       (LEN_BITS'(g + 1)),
            .ctl       (ctl),
            .hist_in   ((g == 0) ? tap[0] : tap[g]),
            .hist_out  (hout[g]),
            .rep_valid (rv[g]),
            .rep       (rp[g]),
            .flush_idx (fidx),
            .flush_cnt (fc[g])
        );
    end

    // Cell len compares with the symbol len back: tap[len-1] before shift.
    always_comb
    begin
        rsel = '0;
        rany = 1'b0;
        for (int i = MAX_PERIOD - 1; i >= 0; i--)
        begin
            if (rep_mask_reg[i])
            begin
                rsel = LEN_BITS'(i);
                rany = 1'b1;
            end
        end
        rest = rep_mask_reg;
        rest[rsel] = 1'b0;
        rsel_res = rep_buf_reg[rsel];
        rsel_res.last = (rest == '0);
    end

    assign c = fc[l_reg - 1'b1];
    assign fvalid = (qabs < pos_reg) && (l_reg >= lo) && (l_reg <= hi)
                    && (qabs + {{(POS_BITS-LEN_BITS){1'b0}}, l_reg} >= pos_reg)
                    && (c > POS_BITS'(1)) && (n_reg < RCNT_BITS'(MAX_RESULTS - 1));
    assign fspan = c * {{(POS_BITS-LEN_BITS){1'b0}}, l_reg};
    assign fq1 = {1'b0, qabs} + 1'b1;
    assign ovalid_load = obuf_free && ((state_reg == ST_REP) || (state_reg == ST_CLOSE)
                         || ((state_reg == ST_FLUSH) && fvalid));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (act_reg == ACT_END)
                begin
                    state_next = ST_FLUSH;
                end
                else if (ctl.shift && (rv != '0))
                begin
                    state_next = ST_REP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REP:
            begin
                if (obuf_free && (rest == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (obuf_free && (q_reg == LEN_BITS'(MAX_PERIOD - 1))
                    && (l_reg == LEN_BITS'(MAX_PERIOD)))
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (obuf_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
            pos_reg <= '0;
            rep_mask_reg <= '0;
            q_reg <= '0;
            l_reg <= LEN_BITS'(1);
            n_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                if (cfg_ch.index == REG_MIN)
                begin
                    min_reg <= cfg_ch.data;
                end
                else
                begin
                    max_reg <= cfg_ch.data;
                end
            end
            if (ovalid_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    q_reg <= '0;
                    l_reg <= LEN_BITS'(1);
                    n_reg <= '0;
                end
                ST_EVAL:
                begin
                    if (ctl.shift)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        rep_mask_reg <= rv;
                    end
                end
                ST_REP:
                begin
                    if (obuf_free)
                    begin
                        rep_mask_reg <= rest;
                    end
                end
                ST_FLUSH:
                begin
                    if (obuf_free)
                    begin
                        if (fvalid)
                        begin
                            n_reg <= n_reg + 1'b1;
                        end
                        if (l_reg == LEN_BITS'(MAX_PERIOD))
                        begin
                            l_reg <= LEN_BITS'(1);
                            q_reg <= q_reg + 1'b1;
                        end
                        else
                        begin
                            l_reg <= l_reg + 1'b1;
                        end
                    end
                end
                ST_CLOSE:
                begin
                    if (obuf_free)
                    begin
                        pos_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            act_reg <= in_ch.action;
            sym_reg <= in_ch.symbol;
        end
        if (state_reg == ST_EVAL)
        begin
            for (int i = 0; i < MAX_PERIOD; i++)
            begin
                rep_buf_reg[i] <= rp[i];
            end
        end
        if (state_reg == ST_REP && obuf_free)
        begin
            obuf_reg <= rsel_res;
        end
        else if (state_reg == ST_FLUSH && obuf_free)
        begin
            obuf_reg.found <= 1'b1;
            obuf_reg.start_pos <= (fspan > {{POS_BITS{1'b0}}, fq1[POS_BITS-1:0]}) ? '0
                : sat_field({{POS_BITS{1'b0}}, fq1[POS_BITS-1:0]} - fspan);
            obuf_reg.period <= l_reg;
            obuf_reg.repeat_count <= sat_field({{POS_BITS{1'b0}}, c});
            obuf_reg.last <= 1'b0;
        end
        else if (state_reg == ST_CLOSE && obuf_free)
        begin
            obuf_reg <= '{found: 1'b0, start_pos: '0, period: '0, repeat_count: '0, last: 1'b1};
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.found = obuf_reg.found;
    assign out_ch.start_pos = obuf_reg.start_pos;
    assign out_ch.period = obuf_reg.period;
    assign out_ch.repeat_count = obuf_reg.repeat_count;
    assign out_ch.last = obuf_reg.last;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && obuf_free) |=> (ovalid_reg && obuf_reg.last))
        else $error("closing record missing last");
    a_rep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REP) |-> rany)
        else $error("report state with no pending report");
    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && obuf_free) |=> (pos_reg == '0))
        else $error("position not cleared");
`endif
endmodule
`default_nettype wire
